FILE: hw/rtl/prpd_pkg.sv
// ----------------------------------------------------------------------------
// prpd_pkg: shared types and constants of the pulse rate peak detector
// Opcodes, field widths, filter coefficients and the word passed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package prpd_pkg;

   localparam int SAMPLE_W = 24;
   localparam int FILT_W   = 26;
   localparam int COEF_W   = 13;
   localparam int COEF_CNT = 101;
   localparam int ACC_W    = 48;
   localparam int SCALE    = 32000;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_NUMERATOR = 2'd0,
      CSR_MIN_INTV  = 2'd1,
      CSR_MAX_INTV  = 2'd2,
      CSR_OFFSET    = 2'd3
   } csr_index_type;

   // Word handed from the front part to the back part.
   typedef struct packed {
      opcode_type                 opcode;
      logic signed [SAMPLE_W-1:0] sample;
   } cmd_type;

   // Symmetric band-pass coefficient; taps past the table have coefficient 0.
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [7:0] k);
      logic [7:0] m;
      logic signed [COEF_W-1:0] c;
      m = (k > 8'd50) ? 8'd100 - k : k;
      unique case (m)
         8'd0:  c = 13'sd0;     8'd1:  c = 13'sd4;     8'd2:  c = 13'sd9;
         8'd3:  c = 13'sd14;    8'd4:  c = 13'sd18;    8'd5:  c = 13'sd20;
         8'd6:  c = 13'sd16;    8'd7:  c = 13'sd6;     8'd8:  c = -13'sd11;
         8'd9:  c = -13'sd34;   8'd10: c = -13'sd61;   8'd11: c = -13'sd88;
         8'd12: c = -13'sd109;  8'd13: c = -13'sd118;  8'd14: c = -13'sd112;
         8'd15: c = -13'sd87;   8'd16: c = -13'sd46;   8'd17: c = 13'sd6;
         8'd18: c = 13'sd61;    8'd19: c = 13'sd107;   8'd20: c = 13'sd136;
         8'd21: c = 13'sd140;   8'd22: c = 13'sd120;   8'd23: c = 13'sd81;
         8'd24: c = 13'sd35;    8'd25: c = 13'sd0;     8'd26: c = -13'sd7;
         8'd27: c = 13'sd28;    8'd28: c = 13'sd111;   8'd29: c = 13'sd235;
         8'd30: c = 13'sd381;   8'd31: c = 13'sd518;   8'd32: c = 13'sd609;
         8'd33: c = 13'sd616;   8'd34: c = 13'sd510;   8'd35: c = 13'sd276;
         8'd36: c = -13'sd76;   8'd37: c = -13'sd514;  8'd38: c = -13'sd983;
         8'd39: c = -13'sd1414; 8'd40: c = -13'sd1733; 8'd41: c = -13'sd1872;
         8'd42: c = -13'sd1787; 8'd43: c = -13'sd1461; 8'd44: c = -13'sd917;
         8'd45: c = -13'sd208;  8'd46: c = 13'sd579;   8'd47: c = 13'sd1343;
         8'd48: c = 13'sd1980;  8'd49: c = 13'sd2403;  8'd50: c = 13'sd2550;
         default: c = 13'sd0;
      endcase
      if (k >= 8'(COEF_CNT)) begin
         c = 13'sd0;
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/prpd_front.sv
// ----------------------------------------------------------------------------
// prpd_front: input stage and command queue
// Registers the input word and keeps a short queue of commands so that the
// input side can keep taking words while the back part works.
// ----------------------------------------------------------------------------
module prpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        opcode,
   input  logic [23:0]       sample,
   output prpd_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_take
);
   import prpd_pkg::*;

   localparam int DEPTH = 4;

   cmd_type    mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 3'(DEPTH));
   assign cmd_valid = (cnt_ff != 3'd0);
   assign cmd       = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // Pointer and count update.
   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= '{opcode: opcode_type'(opcode), sample: signed'(sample)};
      end
   end

endmodule

FILE: hw/rtl/prpd_div.sv
// ----------------------------------------------------------------------------
// prpd_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; divide by zero gives zero.
// ----------------------------------------------------------------------------
module prpd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_in, done_ff;
   logic [16:0] trial;

   assign trial    = {r_ff[15:0], q_ff[31]};
   assign done     = done_ff;
   assign quotient = (d_ff == 16'd0) ? 32'd0 : q_ff;

   // One bit per cycle.
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         n_in    = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff    <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

endmodule

FILE: hw/rtl/prpd_back.sv
// ----------------------------------------------------------------------------
// prpd_back: filter, peak detector and epoch statistics
// Serial multiply-accumulate over the tap memory, then scaling, the slope
// test and up to three serial divisions through one shared divider.
// ----------------------------------------------------------------------------
module prpd_back #(
   parameter int TAPS = 101
) (
   input  logic              clock,
   input  logic              reset,
   input  prpd_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  logic [15:0]       beat_numerator,
   input  logic [7:0]        min_beat_interval,
   input  logic [7:0]        max_beat_interval,
   input  logic [9:0]        slope_offset,
   output logic              res_valid,
   input  logic              res_take,
   output logic [25:0]       res_filtered,
   output logic              res_beat_recorded,
   output logic [15:0]       res_beat_rate,
   output logic [15:0]       res_beat_variation,
   output logic [15:0]       res_epoch_beats,
   output logic [15:0]       res_epoch_avg_rate,
   output logic [15:0]       res_epoch_avg_variation
);
   import prpd_pkg::*;

   localparam int PW = $clog2(TAPS);
   localparam logic [PW-1:0] LAST = PW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] FMAX = ACC_W'(33554431);
   localparam logic signed [ACC_W-1:0] FMIN = -ACC_W'(33554432);
   // ceil(2^38 / 125): exact quotient by 125 for any dividend below 2^31.
   localparam logic [31:0] RECIP125 = 32'd2199023256;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_MAC, S_DRAIN, S_SCALE, S_SLOPE, S_RATE, S_EPOCH,
      S_AVG_R, S_AVG_V, S_OUT
   } state_type;

   state_type state_ff;

   // Tap memory with registered read.
   logic signed [SAMPLE_W-1:0] tap_mem [TAPS];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic [PW-1:0] ptr_ff, pos_ff;
   logic [7:0]    k_ff, kd_ff;
   logic          mac_v_ff, rd_v_ff;
   logic signed [ACC_W-1:0] acc_ff, q_ff;
   logic signed [SAMPLE_W+COEF_W-1:0] prod_ff;
   logic          prod_v_ff;

   // Scaling pipeline.
   logic [ACC_W-1:0] abs_acc;
   logic [30:0]      mag_ff;
   logic [62:0]      rprod_ff;
   logic             neg_ff, neg2_ff;

   // Detector state.
   logic signed [FILT_W-1:0] last_filt_ff, filt_ff;
   logic        slope_pos_ff, recorded_ff;
   logic [15:0] intv_ff, rate_ff, var_ff, cnt_ff, avg_r_ff, avg_v_ff;
   logic [31:0] sum_r_ff, sum_v_ff;
   logic [1:0]  div_step_ff;

   logic        div_start, div_done;
   logic [31:0] div_a, div_q;
   logic [15:0] div_b;

   logic signed [27:0] slope;
   logic [15:0] intv_inc, new_rate, new_var;

   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign res_valid = (state_ff == S_OUT);

   assign res_filtered            = unsigned'(filt_ff);
   assign res_beat_recorded       = recorded_ff;
   assign res_beat_rate           = rate_ff;
   assign res_beat_variation      = var_ff;
   assign res_epoch_beats         = cnt_ff;
   assign res_epoch_avg_rate      = avg_r_ff;
   assign res_epoch_avg_variation = avg_v_ff;

   // Magnitude of the filter sum; the sign is put back after scaling.
   assign abs_acc = acc_ff[ACC_W-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);

   assign slope = 28'(filt_ff) - 28'(last_filt_ff) - 28'(slope_offset);
   assign intv_inc = (intv_ff == 16'hFFFF) ? intv_ff : intv_ff + 16'd1;
   assign new_rate = div_q[15:0];
   assign new_var  = (new_rate > rate_ff) ? new_rate - rate_ff : rate_ff - new_rate;

   prpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // Divider operand selection.
   always_comb begin
      div_start = 1'b0;
      div_a     = {16'd0, beat_numerator};
      div_b     = intv_ff;
      if (state_ff == S_SLOPE) begin
         div_start = 1'b1;
      end else if (state_ff == S_EPOCH) begin
         div_start = (cnt_ff != 16'd0);
         div_a     = sum_r_ff;
         div_b     = cnt_ff;
      end else if (state_ff == S_AVG_R && div_done) begin
         div_start = 1'b1;
         div_a     = sum_v_ff;
         div_b     = cnt_ff;
      end
   end

   // Tap memory clear, write and read, and the multiply stage.
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         tap_mem[ptr_ff] <= '0;
      end else if (cmd_take && (cmd.opcode == OP_SAMPLE)) begin
         tap_mem[ptr_ff] <= cmd.sample;
      end
      rd_data_ff <= tap_mem[pos_ff];
      prod_ff    <= (SAMPLE_W+COEF_W)'(rd_data_ff) * (SAMPLE_W+COEF_W)'(coef_at(kd_ff));
   end

   // Divide by 32000 truncating toward zero: shift out 256, then multiply by
   // the reciprocal of 125. The sum magnitude stays below 2^39.
   always_ff @(posedge clock) begin
      mag_ff   <= abs_acc[38:8];
      neg_ff   <= acc_ff[ACC_W-1];
      rprod_ff <= 63'(mag_ff) * 63'(RECIP125);
      neg2_ff  <= neg_ff;
      q_ff     <= neg2_ff ? -ACC_W'(rprod_ff[62:38]) : ACC_W'(rprod_ff[62:38]);
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         pos_ff       <= '0;
         k_ff         <= '0;
         kd_ff        <= '0;
         mac_v_ff     <= 1'b0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         acc_ff       <= '0;
         filt_ff      <= '0;
         last_filt_ff <= '0;
         slope_pos_ff <= 1'b0;
         recorded_ff  <= 1'b0;
         intv_ff      <= '0;
         rate_ff      <= '0;
         var_ff       <= '0;
         cnt_ff       <= '0;
         sum_r_ff     <= '0;
         sum_v_ff     <= '0;
         avg_r_ff     <= '0;
         avg_v_ff     <= '0;
         div_step_ff  <= '0;
      end else begin
         mac_v_ff  <= (state_ff == S_WRITE) ||
                      ((state_ff == S_MAC) && (k_ff != 8'(TAPS - 1)));
         rd_v_ff   <= mac_v_ff;
         prod_v_ff <= rd_v_ff;
         kd_ff     <= k_ff;
         if (state_ff == S_WRITE) begin
            acc_ff <= '0;
         end else if (prod_v_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         unique case (state_ff)
            S_CLEAR: begin
               // Zero the tap memory once after reset.
               ptr_ff <= (ptr_ff == LAST) ? '0 : ptr_ff + PW'(1);
               if (ptr_ff == LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  recorded_ff <= 1'b0;
                  unique case (cmd.opcode)
                     OP_SAMPLE: state_ff <= S_WRITE;
                     OP_CLEAR: begin
                        cnt_ff   <= '0;
                        sum_r_ff <= '0;
                        sum_v_ff <= '0;
                        state_ff <= S_EPOCH;
                     end
                     OP_RESTART: begin
                        cnt_ff       <= '0;
                        sum_r_ff     <= '0;
                        sum_v_ff     <= '0;
                        last_filt_ff <= '0;
                        filt_ff      <= '0;
                        slope_pos_ff <= 1'b0;
                        intv_ff      <= '0;
                        rate_ff      <= '0;
                        var_ff       <= '0;
                        state_ff     <= S_EPOCH;
                     end
                     default: state_ff <= S_EPOCH;
                  endcase
               end
            end
            S_WRITE: begin
               pos_ff   <= ptr_ff;
               k_ff     <= '0;
               ptr_ff   <= (ptr_ff == LAST) ? '0 : ptr_ff + PW'(1);
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (k_ff == 8'(TAPS - 1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  pos_ff   <= (pos_ff == '0) ? LAST : pos_ff - PW'(1);
                  k_ff     <= k_ff + 8'd1;
               end
            end
            S_DRAIN: begin
               if (!mac_v_ff && !rd_v_ff && !prod_v_ff) begin
                  if (div_step_ff == 2'd2) begin
                     div_step_ff <= '0;
                     state_ff    <= S_SCALE;
                  end else begin
                     div_step_ff <= div_step_ff + 2'd1;
                  end
               end
            end
            S_SCALE: begin
               if (q_ff > FMAX) begin
                  filt_ff <= FMAX[FILT_W-1:0];
               end else if (q_ff < FMIN) begin
                  filt_ff <= FMIN[FILT_W-1:0];
               end else begin
                  filt_ff <= q_ff[FILT_W-1:0];
               end
               intv_ff  <= intv_inc;
               state_ff <= S_SLOPE;
            end
            S_SLOPE: begin
               // Divider starts on numerator / interval here.
               last_filt_ff <= filt_ff;
               slope_pos_ff <= (slope > 28'sd0);
               if (slope_pos_ff && slope < 28'sd0 && intv_ff >= {8'd0, min_beat_interval}) begin
                  if (intv_ff <= {8'd0, max_beat_interval}) begin
                     state_ff <= S_RATE;
                  end else begin
                     intv_ff  <= '0;
                     state_ff <= S_EPOCH;
                  end
               end else begin
                  state_ff <= S_EPOCH;
               end
            end
            S_RATE: begin
               if (div_done) begin
                  if (cnt_ff != 16'hFFFF) begin
                     cnt_ff   <= cnt_ff + 16'd1;
                     sum_r_ff <= sum_r_ff + {16'd0, new_rate};
                     sum_v_ff <= sum_v_ff + {16'd0, new_var};
                  end
                  rate_ff     <= new_rate;
                  var_ff      <= new_var;
                  recorded_ff <= 1'b1;
                  intv_ff     <= '0;
                  state_ff    <= S_EPOCH;
               end
            end
            S_EPOCH: begin
               if (cnt_ff == 16'd0) begin
                  avg_r_ff <= '0;
                  avg_v_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_AVG_R;
               end
            end
            S_AVG_R: begin
               if (div_done) begin
                  avg_r_ff <= div_q[15:0];
                  state_ff <= S_AVG_V;
               end
            end
            S_AVG_V: begin
               if (div_done) begin
                  avg_v_ff <= div_q[15:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (res_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/prpd_out.sv
// ----------------------------------------------------------------------------
// prpd_out: result register
// Holds one finished result word until it is popped.
// ----------------------------------------------------------------------------
module prpd_out (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_take,
   input  logic [25:0] in_filtered,
   input  logic        in_beat_recorded,
   input  logic [15:0] in_beat_rate,
   input  logic [15:0] in_beat_variation,
   input  logic [15:0] in_epoch_beats,
   input  logic [15:0] in_epoch_avg_rate,
   input  logic [15:0] in_epoch_avg_variation,
   output logic        empty,
   input  logic        pop,
   output logic [25:0] filtered,
   output logic        beat_recorded,
   output logic [15:0] beat_rate,
   output logic [15:0] beat_variation,
   output logic [15:0] epoch_beats,
   output logic [15:0] epoch_avg_rate,
   output logic [15:0] epoch_avg_variation
);
   logic full_ff;

   assign empty   = !full_ff;
   assign in_take = in_valid && (!full_ff || pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (in_take) begin
         full_ff <= 1'b1;
      end else if (pop) begin
         full_ff <= 1'b0;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (in_take) begin
         filtered            <= in_filtered;
         beat_recorded       <= in_beat_recorded;
         beat_rate           <= in_beat_rate;
         beat_variation      <= in_beat_variation;
         epoch_beats         <= in_epoch_beats;
         epoch_avg_rate      <= in_epoch_avg_rate;
         epoch_avg_variation <= in_epoch_avg_variation;
      end
   end

endmodule

FILE: hw/rtl/pulse_rate_peak_detector.sv
// ----------------------------------------------------------------------------
// pulse_rate_peak_detector: optical pulse filter and beat rate statistics
// Band-pass FIR, slope peak detector, beat rate and epoch averages.
// ----------------------------------------------------------------------------
// A sample word runs a serial multiply-accumulate over the tap memory
// through a read and multiply pipeline, then a scaling step with registered
// magnitude, reciprocal product and quotient, plus the divisions: one for
// the rate when a beat closes and two for the epoch averages when the epoch
// is not empty, all on one shared serial divider. Commands without a sample
// skip the filter and go straight to the epoch averages. After reset the tap
// memory is cleared; meanwhile words are only queued. Input words wait in a
// four-entry queue and the result sits in an output register, so both sides
// may stall independently.
module pulse_rate_peak_detector #(
   parameter int TAPS = 101
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [23:0] req_sample,
   output logic        empty,
   input  logic        pop,
   output logic [25:0] rsp_filtered,
   output logic        rsp_beat_recorded,
   output logic [15:0] rsp_beat_rate,
   output logic [15:0] rsp_beat_variation,
   output logic [15:0] rsp_epoch_beats,
   output logic [15:0] rsp_epoch_avg_rate,
   output logic [15:0] rsp_epoch_avg_variation,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import prpd_pkg::*;

   cmd_type     cmd;
   logic        cmd_valid, cmd_take, res_valid, res_take, res_rec;
   logic [25:0] res_filt;
   logic [15:0] res_rate, res_var, res_beats, res_avg_r, res_avg_v;
   logic [15:0] numer_ff;
   logic [7:0]  min_ff, max_ff;
   logic [9:0]  offset_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         numer_ff  <= 16'd2400;
         min_ff    <= 8'd12;
         max_ff    <= 8'd54;
         offset_ff <= 10'd15;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUMERATOR: numer_ff  <= csr_data;
            CSR_MIN_INTV:  min_ff    <= csr_data[7:0];
            CSR_MAX_INTV:  max_ff    <= csr_data[7:0];
            CSR_OFFSET:    offset_ff <= csr_data[9:0];
            default:       numer_ff  <= numer_ff;
         endcase
      end
   end

   prpd_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .opcode(req_opcode), .sample(req_sample),
      .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   prpd_back #(.TAPS(TAPS)) u_back (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .beat_numerator(numer_ff), .min_beat_interval(min_ff),
      .max_beat_interval(max_ff), .slope_offset(offset_ff),
      .res_valid(res_valid), .res_take(res_take), .res_filtered(res_filt),
      .res_beat_recorded(res_rec), .res_beat_rate(res_rate),
      .res_beat_variation(res_var), .res_epoch_beats(res_beats),
      .res_epoch_avg_rate(res_avg_r), .res_epoch_avg_variation(res_avg_v)
   );

   prpd_out u_out (
      .clock(clock), .reset(reset), .in_valid(res_valid), .in_take(res_take),
      .in_filtered(res_filt), .in_beat_recorded(res_rec), .in_beat_rate(res_rate),
      .in_beat_variation(res_var), .in_epoch_beats(res_beats),
      .in_epoch_avg_rate(res_avg_r), .in_epoch_avg_variation(res_avg_v),
      .empty(empty), .pop(pop), .filtered(rsp_filtered),
      .beat_recorded(rsp_beat_recorded), .beat_rate(rsp_beat_rate),
      .beat_variation(rsp_beat_variation), .epoch_beats(rsp_epoch_beats),
      .epoch_avg_rate(rsp_epoch_avg_rate),
      .epoch_avg_variation(rsp_epoch_avg_variation)
   );

`ifndef SYNTHESIS
   // A word handed to the output register was produced by the back part.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      res_take |-> res_valid) else $error("result taken without valid");

   // A command is only taken while the queue holds one.
   a_cmd_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("command taken from empty queue");

   // A recorded beat never carries an empty epoch.
   a_beat_epoch: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_beat_recorded) |-> (rsp_epoch_beats != 16'd0))
      else $error("beat recorded with empty epoch");
`endif

endmodule
